[hdl/download_frame_builder_crc16_core_macros.svh]
// Assertion macros shared by the frame builder RTL.
// Each property is sampled on clk and disabled while rst_n is low.
`ifndef DOWNLOAD_FRAME_BUILDER_CRC16_CORE_MACROS_SVH
`define DOWNLOAD_FRAME_BUILDER_CRC16_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define DFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

`define DFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`else

`define DFB_ASSERT_SAME(label, ante, cons)

`define DFB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/dfb_pkg.sv]
package dfb_pkg;

    localparam logic       ACT_START = 1'b0;
    localparam logic       ACT_DATA  = 1'b1;

    localparam logic [7:0]  DIR_HOST_TO_DEVICE = 8'h01;
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'h1021;
    localparam logic [15:0] HDR_LEN            = 16'd4;

    // Position of the byte being emitted for the current item
    localparam logic [2:0] POS_DIR    = 3'd0;
    localparam logic [2:0] POS_STEP   = 3'd1;
    localparam logic [2:0] POS_LEN_LO = 3'd2;
    localparam logic [2:0] POS_LEN_HI = 3'd3;
    localparam logic [2:0] POS_CRC_LO = 3'd4;
    localparam logic [2:0] POS_CRC_HI = 3'd5;
    localparam logic [2:0] POS_DATA       = 3'd0;
    localparam logic [2:0] POS_DATA_CRCLO = 3'd1;

    typedef struct packed {
        logic        valid;
        logic        action;
        logic [7:0]  step_code;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       frame_end;
    } emit_t;

    // CRC-16, MSB first, one byte folded in
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/dfb_in_stage.sv]
module dfb_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // step_code[7:0], payload_length[23:8], data_byte[31:24]
    input  logic          s_tuser,   // action
    input  logic          consume,
    output dfb_pkg::item_t item
);
    import dfb_pkg::*;

    item_t item_reg;
    item_t item_next;

    assign s_tready = !item_reg.valid || consume;
    assign item     = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (s_tvalid && s_tready)
        begin
            item_next.valid          = 1'b1;
            item_next.action         = s_tuser;
            item_next.step_code      = s_tdata[7:0];
            item_next.payload_length = s_tdata[23:8];
            item_next.data_byte      = s_tdata[31:24];
        end
        else if (consume)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

endmodule

[hdl/dfb_emitter.sv]
module dfb_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  dfb_pkg::item_t item,
    input  logic           out_free,
    output logic           consume,
    output dfb_pkg::emit_t emit
);
    import dfb_pkg::*;

    logic        open_reg, open_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  pos_reg, pos_next;

    logic [15:0] total;
    logic [15:0] crc_in;
    logic [7:0]  byte_c;
    logic        upd_crc;
    logic        crc_hi;
    logic        done;
    logic        drop;

    assign total = item.payload_length + HDR_LEN;
    // Only a fresh data request can be dropped; its CRC bytes follow with rem at zero
    assign drop  = (item.action == ACT_DATA) && (pos_reg == POS_DATA) &&
                   (!open_reg || rem_reg == '0);

    // Byte selection for the current position
    always_comb
    begin
        byte_c  = crc_reg[15:8];
        upd_crc = 1'b0;
        crc_hi  = 1'b0;
        done    = 1'b0;
        if (item.action == ACT_START)
        begin
            case (pos_reg)
                POS_DIR:
                begin
                    byte_c  = DIR_HOST_TO_DEVICE;
                    upd_crc = 1'b1;
                end
                POS_STEP:
                begin
                    byte_c  = item.step_code;
                    upd_crc = 1'b1;
                end
                POS_LEN_LO:
                begin
                    byte_c  = total[7:0];
                    upd_crc = 1'b1;
                end
                POS_LEN_HI:
                begin
                    byte_c  = total[15:8];
                    upd_crc = 1'b1;
                    done    = (item.payload_length != '0);
                end
                POS_CRC_LO:
                begin
                    byte_c = crc_reg[7:0];
                end
                default:
                begin
                    byte_c = crc_reg[15:8];
                    crc_hi = 1'b1;
                    done   = 1'b1;
                end
            endcase
        end
        else
        begin
            case (pos_reg)
                POS_DATA:
                begin
                    byte_c  = item.data_byte;
                    upd_crc = 1'b1;
                    done    = (rem_reg != 16'd1);
                end
                POS_DATA_CRCLO:
                begin
                    byte_c = crc_reg[7:0];
                end
                default:
                begin
                    byte_c = crc_reg[15:8];
                    crc_hi = 1'b1;
                    done   = 1'b1;
                end
            endcase
        end
    end

    // A new frame starts its CRC from the initial value
    assign crc_in = (item.action == ACT_START && pos_reg == POS_DIR) ? CRC_INIT : crc_reg;

    always_comb
    begin
        open_next = open_reg;
        rem_next  = rem_reg;
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        consume   = 1'b0;
        emit      = '0;
        if (item.valid)
        begin
            if (drop)
            begin
                consume = 1'b1;
            end
            else if (out_free)
            begin
                emit.valid     = 1'b1;
                emit.out_byte  = byte_c;
                emit.frame_end = crc_hi;
                if (upd_crc)
                begin
                    crc_next = crc_byte(crc_in, byte_c);
                end
                if (item.action == ACT_START && pos_reg == POS_LEN_HI)
                begin
                    open_next = (item.payload_length != '0);
                    rem_next  = item.payload_length;
                end
                if (item.action == ACT_DATA && pos_reg == POS_DATA)
                begin
                    rem_next = rem_reg - 16'd1;
                end
                if (crc_hi)
                begin
                    open_next = 1'b0;
                    rem_next  = '0;
                    crc_next  = CRC_INIT;
                end
                if (done)
                begin
                    consume  = 1'b1;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= '0;
            crc_reg  <= CRC_INIT;
            pos_reg  <= '0;
        end
        else
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

[hdl/dfb_out_reg.sv]
module dfb_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  dfb_pkg::emit_t emit,
    output logic           out_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic           m_tlast
);
    import dfb_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (out_free)
        begin
            valid_next = emit.valid;
            data_next  = emit.out_byte;
            last_next  = emit.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

[hdl/download_frame_builder_crc16_core.sv]
// The first byte of an item passes the item register and the output register to m_tdata.
// Throughput: one byte per cycle unless m_tready stalls the output; a payload byte emits
// 1 byte, the last 3 with its CRC, a start 4 (6 at zero length), one outside a frame none.
// The emitter's single byte-wide CRC step sets this rate: one frame byte per cycle.
// Reset (rst_n low, asynchronous): both stages empty, no frame open, CRC back to 0xFFFF.
`include "download_frame_builder_crc16_core_macros.svh"

module download_frame_builder_crc16_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // step_code[7:0], payload_length[23:8], data_byte[31:24]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);
    import dfb_pkg::*;

    item_t item;
    emit_t emit;
    logic  consume;
    logic  out_free;

    dfb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .consume  (consume),
        .item     (item)
    );

    dfb_emitter u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .out_free (out_free),
        .consume  (consume),
        .emit     (emit)
    );

    dfb_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // never load a byte into a busy output register
    `DFB_ASSERT_SAME(a_emit_has_room, emit.valid, out_free)
    // the CRC high byte always retires its item
    `DFB_ASSERT_SAME(a_end_retires, emit.valid && emit.frame_end, consume)
    // a taken request lands in the item register
    `DFB_ASSERT_NEXT(a_item_loaded, s_tvalid && s_tready, item.valid)

endmodule
